[sv/sbd_pkg.sv]
// Package with the types, constants and key folding shared by the sort block.
`timescale 1ns / 1ps
package sbd_pkg;

   localparam int MAX_RECORDS_DEFAULT = 64;
   localparam int CHAIN_DEPTH = 64;
   localparam int INDEX_W = 6;
   localparam int KEY_W = 31;

   localparam int MINUTES_PER_HOUR = 60;
   localparam int HOURS_PER_DAY = 24;
   localparam int DAYS_PER_MONTH = 31;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int DAY_MINUTES = MINUTES_PER_HOUR * HOURS_PER_DAY;
   localparam int MONTH_MINUTES = DAY_MINUTES * DAYS_PER_MONTH;
   localparam int YEAR_MINUTES = MONTH_MINUTES * MONTHS_PER_YEAR;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_UNLOAD
   } state_type;

   typedef struct packed {
      logic                    valid;
      logic signed [KEY_W-1:0] end_key;
      logic signed [KEY_W-1:0] start_key;
      logic [INDEX_W-1:0]      index;
   } cell_data_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   function automatic logic signed [KEY_W-1:0] fold_time(
      input logic signed [10:0] year,
      input logic signed [4:0]  month,
      input logic signed [5:0]  day,
      input logic signed [5:0]  hour,
      input logic signed [6:0]  minute
   );
      logic signed [KEY_W-1:0] y_v;
      logic signed [KEY_W-1:0] mo_v;
      logic signed [KEY_W-1:0] d_v;
      logic signed [KEY_W-1:0] h_v;
      logic signed [KEY_W-1:0] mi_v;
      y_v  = (year == '1) ? '0 : KEY_W'(year);
      mo_v = (month == '1) ? '0 : KEY_W'(month);
      d_v  = (day == '1) ? '0 : KEY_W'(day);
      h_v  = (hour == '1) ? '0 : KEY_W'(hour);
      mi_v = (minute == '1) ? '0 : KEY_W'(minute);
      return KEY_W'(y_v * KEY_W'(YEAR_MINUTES))
           + KEY_W'(mo_v * KEY_W'(MONTH_MINUTES))
           + KEY_W'(d_v * KEY_W'(DAY_MINUTES))
           + KEY_W'(h_v * KEY_W'(MINUTES_PER_HOUR))
           + mi_v;
   endfunction

   function automatic logic sorts_after(input cell_data_type a, input cell_data_type b);
      if (a.end_key != b.end_key) begin
         return a.end_key > b.end_key;
      end
      return a.start_key > b.start_key;
   endfunction

endpackage

[sv/sbd_cell.sv]
// One cell of the sorted chain: holds one record and inserts or shifts in place.
`timescale 1ns / 1ps
module sbd_cell
   import sbd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_data_type new_data,
   input  cell_data_type prev_data,
   input  logic          prev_after,
   input  cell_data_type next_data,
   output cell_data_type data,
   output logic          after
);

   cell_data_type data_ff;
   cell_data_type data_in;

   always_comb begin
      after = !data_ff.valid || sorts_after(data_ff, new_data);
      data_in = data_ff;
      if (ctrl.shift) begin
         data_in = next_data;
      end else if (ctrl.insert && after) begin
         data_in = prev_after ? prev_data : new_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

[sv/sort_by_deadline_then_start_top.sv]
// Top level of the stable record sorter built on a chain of insertion cells.
//
// Usage: a record (end time, start time, is_last) is a transaction on the
// request side, taken at a rising edge where start is high and busy is low.
// Both times are folded into minute keys in the accepting cycle, and in the
// next cycle the record is inserted into the cell chain by a broadcast
// compare in every cell; busy stays high meanwhile, so no new record is taken.
// Records beyond the capacity of min(MAX_RECORDS, 64) are dropped.
// When the record marked last has been inserted, the chain is unloaded from
// its head, one cell shift per cycle: one response transaction per stored
// record, shown for exactly one cycle with rsp_strobe, in ascending order of
// end key then start key, ties in arrival order, rsp_last_out on the final one.
// The first response is loaded from the chain head in the unload state that
// follows the insertion of the last record, and busy stays high until the
// final response is on the ports. The receiver cannot stall responses.
// Reset empties the chain and the record count; no clearing pass is needed.
`timescale 1ns / 1ps
module sort_by_deadline_then_start_top
   import sbd_pkg::*;
#(
   parameter int MAX_RECORDS = MAX_RECORDS_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [10:0]        req_end_year,
   input  logic signed [4:0]         req_end_month,
   input  logic signed [5:0]         req_end_day,
   input  logic signed [5:0]         req_end_hour,
   input  logic signed [6:0]         req_end_minute,
   input  logic signed [10:0]        req_start_year,
   input  logic signed [4:0]         req_start_month,
   input  logic signed [5:0]         req_start_day,
   input  logic signed [5:0]         req_start_hour,
   input  logic signed [6:0]         req_start_minute,
   input  logic                      req_is_last,
   output logic                      rsp_strobe,
   output logic [INDEX_W-1:0]        rsp_record_index,
   output logic                      rsp_last_out
);

   localparam int DEPTH = (MAX_RECORDS < CHAIN_DEPTH) ? MAX_RECORDS : CHAIN_DEPTH;
   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type state_ff;
   state_type state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic signed [KEY_W-1:0] end_key_ff;
   logic signed [KEY_W-1:0] start_key_ff;
   logic last_ff;
   logic rsp_strobe_ff;
   logic rsp_strobe_in;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic rsp_last_ff;
   logic rsp_last_in;
   logic accept;
   cell_ctrl_type ctrl;
   cell_data_type new_data;
   cell_data_type cell_q [DEPTH];
   logic cell_after [DEPTH];

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      new_data.valid = 1'b1;
      new_data.end_key = end_key_ff;
      new_data.start_key = start_key_ff;
      new_data.index = INDEX_W'(count_ff);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ctrl = '0;
      rsp_strobe_in = 1'b0;
      rsp_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (count_ff < CNT_W'(DEPTH)) begin
               ctrl.insert = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = last_ff ? ST_UNLOAD : ST_IDLE;
         end
         ST_UNLOAD: begin
            ctrl.shift = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_last_in = (count_ff == CNT_W'(1));
            count_in = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         end_key_ff <= fold_time(req_end_year, req_end_month, req_end_day,
                                 req_end_hour, req_end_minute);
         start_key_ff <= fold_time(req_start_year, req_start_month, req_start_day,
                                   req_start_hour, req_start_minute);
         last_ff <= req_is_last;
      end
      if (rsp_strobe_in) begin
         rsp_index_ff <= cell_q[0].index;
         rsp_last_ff <= rsp_last_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_data_type prev_data;
      logic prev_after;
      cell_data_type next_data;
      if (i == 0) begin : g_head
         assign prev_data = '0;
         assign prev_after = 1'b0;
      end else begin : g_body
         assign prev_data = cell_q[i-1];
         assign prev_after = cell_after[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign next_data = '0;
      end else begin : g_inner
         assign next_data = cell_q[i+1];
      end
      sbd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_data   (new_data),
         .prev_data  (prev_data),
         .prev_after (prev_after),
         .next_data  (next_data),
         .data       (cell_q[i]),
         .after      (cell_after[i])
      );
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_record_index = rsp_index_ff;
   assign rsp_last_out = rsp_last_ff;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the stable deadline-then-start record sorter.
`timescale 1ns / 1ps
module tb_top
   import sbd_pkg::*;
();

   localparam int CAPACITY = (MAX_RECORDS_DEFAULT < CHAIN_DEPTH) ?
                             MAX_RECORDS_DEFAULT : CHAIN_DEPTH;
   localparam int ITEM_TARGET = 270;

   typedef struct {
      logic signed [10:0] ey;
      logic signed [4:0]  emo;
      logic signed [5:0]  ed;
      logic signed [5:0]  eh;
      logic signed [6:0]  emi;
      logic signed [10:0] sy;
      logic signed [4:0]  smo;
      logic signed [5:0]  sd;
      logic signed [5:0]  sh;
      logic signed [6:0]  smi;
      logic               last;
      int                 gap;
      bit                 drain;
   } record_type;

   typedef struct {
      logic [INDEX_W-1:0] index;
      logic               last;
   } sorted_entry_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [10:0] req_end_year = '0;
   logic signed [4:0]  req_end_month = '0;
   logic signed [5:0]  req_end_day = '0;
   logic signed [5:0]  req_end_hour = '0;
   logic signed [6:0]  req_end_minute = '0;
   logic signed [10:0] req_start_year = '0;
   logic signed [4:0]  req_start_month = '0;
   logic signed [5:0]  req_start_day = '0;
   logic signed [5:0]  req_start_hour = '0;
   logic signed [6:0]  req_start_minute = '0;
   logic               req_is_last = 1'b0;
   logic               rsp_strobe;
   logic [INDEX_W-1:0] rsp_record_index;
   logic               rsp_last_out;

   record_type       record_queue[$];
   sorted_entry_type sorted_index_q[$];
   record_type       cur;
   bit               driving = 0;
   int               hold_left = 0;
   int               n_issued = 0;
   int               n_accepted = 0;
   int               failures = 0;

   longint             end_key_mem[CAPACITY];
   longint             start_key_mem[CAPACITY];
   logic [INDEX_W-1:0] sorted_order[CAPACITY];
   int                 stored_count = 0;

   sort_by_deadline_then_start_top dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_end_year(req_end_year),
      .req_end_month(req_end_month),
      .req_end_day(req_end_day),
      .req_end_hour(req_end_hour),
      .req_end_minute(req_end_minute),
      .req_start_year(req_start_year),
      .req_start_month(req_start_month),
      .req_start_day(req_start_day),
      .req_start_hour(req_start_hour),
      .req_start_minute(req_start_minute),
      .req_is_last(req_is_last),
      .rsp_strobe(rsp_strobe),
      .rsp_record_index(rsp_record_index),
      .rsp_last_out(rsp_last_out)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic longint field_minutes(input longint v);
      return (v == -1) ? 0 : v;
   endfunction

   function automatic longint minute_key(input logic signed [10:0] y,
                                         input logic signed [4:0] mo,
                                         input logic signed [5:0] d,
                                         input logic signed [5:0] h,
                                         input logic signed [6:0] mi);
      return field_minutes(y) * YEAR_MINUTES + field_minutes(mo) * MONTH_MINUTES
           + field_minutes(d) * DAY_MINUTES + field_minutes(h) * MINUTES_PER_HOUR
           + field_minutes(mi);
   endfunction

   function automatic bit later_than(input longint ae, input longint as_key,
                                     input longint be, input longint bs_key);
      if (ae != be) begin
         return ae > be;
      end
      return as_key > bs_key;
   endfunction

   task automatic insert_record(input record_type r);
      longint           ek;
      longint           sk;
      int               pos;
      sorted_entry_type e;
      ek = minute_key(r.ey, r.emo, r.ed, r.eh, r.emi);
      sk = minute_key(r.sy, r.smo, r.sd, r.sh, r.smi);
      if (stored_count < CAPACITY) begin
         end_key_mem[stored_count] = ek;
         start_key_mem[stored_count] = sk;
         pos = stored_count;
         while (pos > 0 && later_than(end_key_mem[sorted_order[pos-1]],
                                      start_key_mem[sorted_order[pos-1]], ek, sk)) begin
            sorted_order[pos] = sorted_order[pos-1];
            pos--;
         end
         sorted_order[pos] = INDEX_W'(stored_count);
         stored_count++;
      end
      if (r.last) begin
         for (int k = 0; k < stored_count; k++) begin
            e.index = sorted_order[k];
            e.last = (k == stored_count - 1);
            sorted_index_q.push_back(e);
         end
         stored_count = 0;
      end
   endtask

   function automatic int pick_gap(input bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 45) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_field(input int w, input int hi);
      case ($urandom_range(0, 9)) inside
         0: return -1;
         1: return hi;
         [2:5]: return $urandom_range(0, hi);
         6: return int'($urandom_range(0, (1 << w) - 1)) - (1 << (w - 1));
         default: return $urandom_range(0, 1);
      endcase
   endfunction

   function automatic record_type make_record(input int ey, input int emo, input int ed,
                                              input int eh, input int emi, input int sy,
                                              input int smo, input int sd, input int sh,
                                              input int smi, input bit last);
      record_type r;
      r.ey = 11'(ey);
      r.emo = 5'(emo);
      r.ed = 6'(ed);
      r.eh = 6'(eh);
      r.emi = 7'(emi);
      r.sy = 11'(sy);
      r.smo = 5'(smo);
      r.sd = 6'(sd);
      r.sh = 6'(sh);
      r.smi = 7'(smi);
      r.last = last;
      r.gap = pick_gap(0);
      r.drain = 0;
      return r;
   endfunction

   task automatic add_random_set(input int size, input bit drain_first);
      record_type r;
      record_type prev;
      bit         no_idle;
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < size; i++) begin
         if (i > 0 && $urandom_range(0, 3) == 0) begin
            r = prev;
         end else begin
            r = make_record(pick_field(11, 1023), pick_field(5, 11), pick_field(6, 31),
                            pick_field(6, 23), pick_field(7, 59), pick_field(11, 1023),
                            pick_field(5, 11), pick_field(6, 31), pick_field(6, 23),
                            pick_field(7, 59), 0);
         end
         r.last = (i == size - 1);
         r.gap = pick_gap(no_idle);
         r.drain = drain_first && (i == 0);
         record_queue.push_back(r);
         prev = r;
      end
   endtask

   // Acceptance is sampled at the rising edge and fed straight into the prediction.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         insert_record(cur);
         n_accepted++;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (driving && n_accepted == n_issued) begin
            driving = 0;
            hold_left = (record_queue.size() != 0) ? record_queue[0].gap : 0;
         end
         if (!driving && record_queue.size() != 0) begin
            if (hold_left > 0) begin
               hold_left--;
            end else if (!record_queue[0].drain || sorted_index_q.size() == 0) begin
               cur = record_queue.pop_front();
               n_issued++;
               driving = 1;
            end
         end
         start <= driving;
         req_end_year <= cur.ey;
         req_end_month <= cur.emo;
         req_end_day <= cur.ed;
         req_end_hour <= cur.eh;
         req_end_minute <= cur.emi;
         req_start_year <= cur.sy;
         req_start_month <= cur.smo;
         req_start_day <= cur.sd;
         req_start_hour <= cur.sh;
         req_start_minute <= cur.smi;
         req_is_last <= cur.last;
      end
   end

   always @(posedge clock) begin
      sorted_entry_type e;
      if (!reset && rsp_strobe) begin
         if (sorted_index_q.size() == 0) begin
            $error("Unexpected response transaction: record_index %0d, last_out %0d",
                   rsp_record_index, rsp_last_out);
            failures++;
         end else begin
            e = sorted_index_q.pop_front();
            if (rsp_record_index !== e.index) begin
               $error("record_index mismatch: expected %0d, actual %0d",
                      e.index, rsp_record_index);
               failures++;
            end
            if (rsp_last_out !== e.last) begin
               $error("last_out mismatch: expected %0d, actual %0d", e.last, rsp_last_out);
               failures++;
            end
         end
      end
   end

   initial begin
      int big;
      record_queue.push_back(make_record(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 1));
      record_queue.push_back(make_record(1023, 11, 31, 23, 59, 1023, 11, 31, 23, 59, 0));
      record_queue.push_back(make_record(-1024, -16, -32, -32, -64,
                                         -1024, -16, -32, -32, -64, 0));
      record_queue.push_back(make_record(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      record_queue.push_back(make_record(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0));
      record_queue.push_back(make_record(1023, 15, 31, 31, 63, 1023, 15, 31, 31, 63, 0));
      record_queue.push_back(make_record(1023, 11, 31, 23, 59, 1023, 11, 31, 23, 59, 1));
      record_queue.push_back(make_record(100, 5, 10, 12, 30, 50, 0, 0, 0, 3, 0));
      record_queue.push_back(make_record(100, 5, 10, 12, 30, 50, 0, 0, 0, 2, 0));
      record_queue.push_back(make_record(100, 5, 10, 12, 30, -1, 0, 0, 0, 1, 1));
      record_queue.push_back(make_record(120, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      record_queue.push_back(make_record(110, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      record_queue.push_back(make_record(100, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      record_queue.push_back(make_record(90, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1));
      record_queue[0].drain = 1;
      add_random_set(5, 1);
      add_random_set(CAPACITY, 0);
      while (record_queue.size() < 110) begin
         add_random_set($urandom_range(1, 6), $urandom_range(0, 7) == 0);
      end
      // The oversized set drops its tail, including the record that closes it.
      add_random_set(CAPACITY + 3, 1);
      while (record_queue.size() < ITEM_TARGET) begin
         big = ($urandom_range(0, 9) == 0);
         add_random_set(big ? $urandom_range(9, 20) : $urandom_range(1, 6),
                        $urandom_range(0, 7) == 0);
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (record_queue.size() != 0 || driving || sorted_index_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
